[sv/mtm_pkg.sv]
// ----------------------------------------------------------------------------
// mtm_pkg
// Shared types and constants for the mutex table manager: table sizes,
// command and status codes, transfer payloads and memory word layouts.
// ----------------------------------------------------------------------------
package mtm_pkg;

  localparam int NUM_MUTEXES = 64;
  localparam int NUM_THREADS = 16;
  localparam int NUM_PROCS   = 64;

  localparam int WAIT_DEPTH = NUM_PROCS * NUM_THREADS;

  localparam int MW  = $clog2(NUM_MUTEXES);
  localparam int TW  = $clog2(NUM_THREADS);
  localparam int WAW = $clog2(WAIT_DEPTH);
  localparam int SW  = (MW > TW) ? MW : TW;

  localparam int F_CMD_W   = 2;
  localparam int F_MUTEX_W = 6;
  localparam int F_PROC_W  = 6;
  localparam int F_THR_W   = 4;
  localparam int F_STAT_W  = 2;

  localparam logic [F_CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [F_CMD_W-1:0] CMD_DEALLOC = 2'd1;
  localparam logic [F_CMD_W-1:0] CMD_LOCK    = 2'd2;
  localparam logic [F_CMD_W-1:0] CMD_UNLOCK  = 2'd3;

  localparam logic [F_STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [F_STAT_W-1:0] ST_ERR     = 2'd1;
  localparam logic [F_STAT_W-1:0] ST_BLOCKED = 2'd2;

  typedef struct packed {
    logic [F_CMD_W-1:0]   cmd;
    logic [F_MUTEX_W-1:0] mutex_index;
    logic [F_PROC_W-1:0]  proc_slot;
    logic [F_THR_W-1:0]   thread_slot;
  } req_t;

  typedef struct packed {
    logic [F_STAT_W-1:0]  status;
    logic [F_MUTEX_W-1:0] alloc_index;
    logic                 woken_valid;
    logic [F_THR_W-1:0]   woken_thread;
  } rsp_t;

  typedef struct packed {
    logic [F_PROC_W-1:0] owner;
    logic [TW-1:0]       holder;
  } entry_t;

  typedef struct packed {
    logic          blocked;
    logic [MW-1:0] mutex;
  } waiter_t;

  typedef struct packed {
    logic          we;
    logic [MW-1:0] addr;
    entry_t        data;
  } ent_wr_t;

  typedef struct packed {
    logic           we;
    logic [WAW-1:0] addr;
    waiter_t        data;
  } wt_wr_t;

endpackage

[sv/mutex_table_manager.sv]
// ----------------------------------------------------------------------------
// mutex_table_manager
// Mutex table with alloc, dealloc, lock and unlock, and direct handoff of an
// unlocked mutex to the next waiting thread of the owning process.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transfer takes place when start is high and busy is
//   low; req carries cmd, mutex_index, proc_slot and thread_slot.
//   Result channel: done pulses for one cycle with rsp valid; every command
//   gives exactly one result. The receiver cannot stall: rsp is shown once.
//   Dealloc, lock and commands refused in S_EVAL answer from S_EVAL.
//   Alloc searches the entries in S_ALLOC from index 0 up to the first
//   free one. Unlock walks the waiter slots in S_SCAN, one slot per cycle,
//   with the shared scan counter against the waiter memory read port.
//   busy stays high from the transfer until done, so one command is in
//   flight at a time.
//   Reset: flag vectors clear at once; the waiter memory is then swept,
//   one slot a cycle, over all 1024 slots with busy held high.
// ----------------------------------------------------------------------------
module mutex_table_manager (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mtm_pkg::req_t req,
  output logic          done,
  output mtm_pkg::rsp_t rsp
);
  import mtm_pkg::*;

  ent_wr_t         ent_wr;
  logic [MW-1:0]   ent_raddr;
  entry_t          ent_rdata;
  wt_wr_t          wt_wr;
  logic [WAW-1:0]  wt_raddr;
  waiter_t         wt_rdata;

  mtm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .ent_wr    (ent_wr),
    .ent_raddr (ent_raddr),
    .ent_rdata (ent_rdata),
    .wt_wr     (wt_wr),
    .wt_raddr  (wt_raddr),
    .wt_rdata  (wt_rdata)
  );

  mtm_ram #(
    .DEPTH (NUM_MUTEXES),
    .WIDTH ($bits(entry_t))
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_wr.we),
    .waddr (ent_wr.addr),
    .wdata (ent_wr.data),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  mtm_ram #(
    .DEPTH (WAIT_DEPTH),
    .WIDTH ($bits(waiter_t))
  ) u_waiter_ram (
    .clk   (clk),
    .we    (wt_wr.we),
    .waddr (wt_wr.addr),
    .wdata (wt_wr.data),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

endmodule

[sv/mtm_ram.sv]
// ----------------------------------------------------------------------------
// mtm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mtm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/mtm_ctrl.sv]
// ----------------------------------------------------------------------------
// mtm_ctrl
// Command sequencer: holds the per-mutex flag vectors, evaluates commands,
// and drives one shared scan counter for free-entry search and waiter handoff.
// ----------------------------------------------------------------------------
module mtm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  mtm_pkg::req_t   req,
  output logic            done,
  output mtm_pkg::rsp_t   rsp,
  output mtm_pkg::ent_wr_t ent_wr,
  output logic [mtm_pkg::MW-1:0] ent_raddr,
  input  mtm_pkg::entry_t ent_rdata,
  output mtm_pkg::wt_wr_t wt_wr,
  output logic [mtm_pkg::WAW-1:0] wt_raddr,
  input  mtm_pkg::waiter_t wt_rdata
);
  import mtm_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_ALLOC = 5'b01000,
    S_SCAN  = 5'b10000
  } state_t;

  state_t                 state, state_next;
  req_t                   req_q, req_q_next;
  logic [SW-1:0]          scan, scan_next;
  logic [TW-1:0]          cand, cand_next;
  logic [WAW-1:0]         clr, clr_next;
  logic                   done_next;
  rsp_t                   rsp_next;
  logic [NUM_MUTEXES-1:0] alloc_v, alloc_next;
  logic [NUM_MUTEXES-1:0] locked_v, locked_next;
  logic [NUM_MUTEXES-1:0] hvalid_v, hvalid_next;

  logic [MW-1:0] mx;
  logic [MW-1:0] aidx;
  logic [TW-1:0] th;
  logic          caller_bad;
  logic          mx_bad;

  function automatic logic [TW-1:0] next_thr(input logic [TW-1:0] c);
    logic [TW-1:0] r;
    if (int'(c) == NUM_THREADS - 1) begin
      r = '0;
    end else begin
      r = c + TW'(1);
    end
    return r;
  endfunction

  function automatic logic [WAW-1:0] wt_addr(input logic [F_PROC_W-1:0] p,
                                             input logic [TW-1:0] c);
    return WAW'(int'(p) * NUM_THREADS + int'(c));
  endfunction

  assign mx         = MW'(req_q.mutex_index);
  assign aidx       = scan[MW-1:0];
  assign th         = TW'(req_q.thread_slot);
  assign caller_bad = (int'(req_q.proc_slot) >= NUM_PROCS) ||
                      (int'(req_q.thread_slot) >= NUM_THREADS);
  assign mx_bad     = int'(req_q.mutex_index) >= NUM_MUTEXES;
  assign busy       = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    req_q_next  = req_q;
    scan_next   = scan;
    cand_next   = cand;
    clr_next    = clr;
    done_next   = 1'b0;
    rsp_next    = rsp;
    alloc_next  = alloc_v;
    locked_next = locked_v;
    hvalid_next = hvalid_v;
    ent_wr      = '0;
    wt_wr       = '0;
    ent_raddr   = (state == S_IDLE) ? MW'(req.mutex_index) : mx;
    wt_raddr    = wt_addr(req_q.proc_slot, next_thr(cand));

    unique case (state)
      S_CLEAR: begin
        wt_wr.we   = 1'b1;
        wt_wr.addr = clr;
        clr_next   = clr + WAW'(1);
        if (int'(clr) == WAIT_DEPTH - 1) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          req_q_next = req;
          state_next = S_EVAL;
        end
      end

      S_EVAL: begin
        rsp_next        = '0;
        rsp_next.status = ST_ERR;
        done_next       = 1'b1;
        state_next      = S_IDLE;
        if (caller_bad) begin
          // error, no state change
        end else if (req_q.cmd == CMD_ALLOC) begin
          done_next  = 1'b0;
          state_next = S_ALLOC;
          scan_next  = '0;
        end else if (mx_bad || !alloc_v[mx] || ent_rdata.owner != req_q.proc_slot) begin
          // error, no state change
        end else begin
          unique case (req_q.cmd)
            CMD_DEALLOC: begin
              if (!locked_v[mx]) begin
                alloc_next[mx]  = 1'b0;
                locked_next[mx] = 1'b0;
                hvalid_next[mx] = 1'b0;
                rsp_next.status = ST_OK;
              end
            end
            CMD_LOCK: begin
              if (hvalid_v[mx] && ent_rdata.holder == th) begin
                // relock by holder
              end else if (locked_v[mx]) begin
                wt_wr.we           = 1'b1;
                wt_wr.addr         = wt_addr(req_q.proc_slot, th);
                wt_wr.data.blocked = 1'b1;
                wt_wr.data.mutex   = mx;
                rsp_next.status    = ST_BLOCKED;
              end else begin
                locked_next[mx]    = 1'b1;
                hvalid_next[mx]    = 1'b1;
                ent_wr.we          = 1'b1;
                ent_wr.addr        = mx;
                ent_wr.data.owner  = req_q.proc_slot;
                ent_wr.data.holder = th;
                rsp_next.status    = ST_OK;
              end
            end
            CMD_UNLOCK: begin
              if (hvalid_v[mx] && ent_rdata.holder == th) begin
                done_next  = 1'b0;
                state_next = S_SCAN;
                wt_raddr   = wt_addr(req_q.proc_slot, next_thr(th));
                cand_next  = next_thr(th);
                scan_next  = SW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (!alloc_v[aidx]) begin
          alloc_next[aidx]     = 1'b1;
          locked_next[aidx]    = 1'b0;
          hvalid_next[aidx]    = 1'b0;
          ent_wr.we            = 1'b1;
          ent_wr.addr          = aidx;
          ent_wr.data.owner    = req_q.proc_slot;
          rsp_next             = '0;
          rsp_next.status      = ST_OK;
          rsp_next.alloc_index = F_MUTEX_W'(aidx);
          done_next            = 1'b1;
          state_next           = S_IDLE;
        end else if (int'(aidx) == NUM_MUTEXES - 1) begin
          rsp_next        = '0;
          rsp_next.status = ST_ERR;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          scan_next = scan + SW'(1);
        end
      end

      S_SCAN: begin
        rsp_next        = '0;
        rsp_next.status = ST_OK;
        if (wt_rdata.blocked && wt_rdata.mutex == mx) begin
          wt_wr.we                = 1'b1;
          wt_wr.addr              = wt_addr(req_q.proc_slot, cand);
          wt_wr.data              = '0;
          ent_wr.we               = 1'b1;
          ent_wr.addr             = mx;
          ent_wr.data.owner       = req_q.proc_slot;
          ent_wr.data.holder      = cand;
          rsp_next.woken_valid    = 1'b1;
          rsp_next.woken_thread   = F_THR_W'(cand);
          done_next               = 1'b1;
          state_next              = S_IDLE;
        end else if (int'(scan) == NUM_THREADS - 1) begin
          locked_next[mx] = 1'b0;
          hvalid_next[mx] = 1'b0;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cand_next = next_thr(cand);
          scan_next = scan + SW'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      done     <= 1'b0;
      alloc_v  <= '0;
      locked_v <= '0;
      hvalid_v <= '0;
    end else begin
      state    <= state_next;
      clr      <= clr_next;
      done     <= done_next;
      alloc_v  <= alloc_next;
      locked_v <= locked_next;
      hvalid_v <= hvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q <= req_q_next;
    scan  <= scan_next;
    cand  <= cand_next;
    rsp   <= rsp_next;
  end

endmodule

[sv/mtm_checker.sv]
// ----------------------------------------------------------------------------
// mtm_checker
// Port-level checks on the mutex table manager, bound to the top level.
// ----------------------------------------------------------------------------
module mtm_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input mtm_pkg::rsp_t rsp
);
  import mtm_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transfer not followed by busy");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on consecutive cycles");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_OK || rsp.status == ST_ERR || rsp.status == ST_BLOCKED))
    else $error("undefined status code");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |->
      rsp.alloc_index == '0 && !rsp.woken_valid && rsp.woken_thread == '0)
    else $error("failing result carries payload");

  a_handoff_ok: assert property (@(posedge clk) disable iff (rst)
    done && rsp.woken_valid |-> rsp.status == ST_OK && rsp.alloc_index == '0)
    else $error("handoff with bad status");

endmodule

bind mutex_table_manager mtm_checker u_mtm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

[sim/mutex_table_manager_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mutex_table_manager_tb
// Self-checking bench for the mutex table manager. A behavioral copy of the
// table (entries, holders, blocked waiters) predicts the response to every
// accepted command; each done pulse is compared field by field with the
// oldest prediction. Directed checks cover errors, blocking, handoff order
// and table full; the random phase mixes owner-aware traffic with noise.
// ----------------------------------------------------------------------------
module mutex_table_manager_tb;

  import mtm_pkg::*;

  localparam int NONE = -1;

  logic clk;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req   = '0;
  rsp_t rsp;

  // Predicted table state
  bit                  ent_alloc  [NUM_MUTEXES];
  bit                  ent_locked [NUM_MUTEXES];
  bit [F_PROC_W-1:0]   ent_owner  [NUM_MUTEXES];
  bit                  ent_hv     [NUM_MUTEXES];
  bit [F_THR_W-1:0]    ent_ht     [NUM_MUTEXES];
  bit                  wt_blocked [WAIT_DEPTH];
  bit [F_MUTEX_W-1:0]  wt_mutex   [WAIT_DEPTH];

  rsp_t              pending_rsp_q[$];
  int                err_count = 0;
  bit                no_gap    = 1'b0;
  logic [F_PROC_W-1:0] proc_pool[4];

  mutex_table_manager i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic rsp_t apply_cmd(req_t r);
    rsp_t res;
    int   base;
    int   m;
    int   w;
    int   cand;
    res        = '0;
    res.status = ST_ERR;
    if (int'(r.proc_slot) >= NUM_PROCS || int'(r.thread_slot) >= NUM_THREADS) return res;
    base = int'(r.proc_slot) * NUM_THREADS;
    if (r.cmd == CMD_ALLOC) begin
      for (int k = 0; k < NUM_MUTEXES; k++) begin
        if (!ent_alloc[k]) begin
          ent_alloc[k]    = 1'b1;
          ent_locked[k]   = 1'b0;
          ent_owner[k]    = r.proc_slot;
          ent_hv[k]       = 1'b0;
          res.status      = ST_OK;
          res.alloc_index = F_MUTEX_W'(k);
          return res;
        end
      end
      return res;
    end
    if (int'(r.mutex_index) >= NUM_MUTEXES) return res;
    m = int'(r.mutex_index);
    if (!ent_alloc[m] || ent_owner[m] != r.proc_slot) return res;
    case (r.cmd)
      CMD_DEALLOC: begin
        if (ent_locked[m]) return res;
        ent_alloc[m]  = 1'b0;
        ent_locked[m] = 1'b0;
        ent_hv[m]     = 1'b0;
        res.status    = ST_OK;
      end
      CMD_LOCK: begin
        if (ent_hv[m] && ent_ht[m] == r.thread_slot) return res;
        if (ent_locked[m]) begin
          wt_blocked[base + int'(r.thread_slot)] = 1'b1;
          wt_mutex[base + int'(r.thread_slot)]   = F_MUTEX_W'(m);
          res.status = ST_BLOCKED;
        end else begin
          ent_locked[m] = 1'b1;
          ent_hv[m]     = 1'b1;
          ent_ht[m]     = r.thread_slot;
          res.status    = ST_OK;
        end
      end
      default: begin
        if (!ent_hv[m] || ent_ht[m] != r.thread_slot) return res;
        res.status = ST_OK;
        for (int k = 1; k < NUM_THREADS; k++) begin
          cand = (int'(r.thread_slot) + k) % NUM_THREADS;
          w    = base + cand;
          if (wt_blocked[w] && int'(wt_mutex[w]) == m) begin
            wt_blocked[w]    = 1'b0;
            ent_ht[m]        = F_THR_W'(cand);
            res.woken_valid  = 1'b1;
            res.woken_thread = F_THR_W'(cand);
            return res;
          end
        end
        ent_locked[m] = 1'b0;
        ent_hv[m]     = 1'b0;
      end
    endcase
    return res;
  endfunction

  // mode 0: any owned entry, 1: owned and unlocked, 2: owned and locked
  function automatic int pick_owned(logic [F_PROC_W-1:0] p, int mode);
    int cand[$];
    for (int k = 0; k < NUM_MUTEXES; k++) begin
      if (ent_alloc[k] && ent_owner[k] == p &&
          (mode == 0 || (mode == 1 && !ent_locked[k]) || (mode == 2 && ent_locked[k])))
        cand.push_back(k);
    end
    if (cand.size() == 0) return NONE;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gap) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic idle_for(int n);
    req_t noise;
    if (n > 0) begin
      noise.cmd         = F_CMD_W'($urandom_range(0, 3));
      noise.mutex_index = F_MUTEX_W'($urandom_range(0, 63));
      noise.proc_slot   = F_PROC_W'($urandom_range(0, 63));
      noise.thread_slot = F_THR_W'($urandom_range(0, 15));
      start <= 1'b0;
      req   <= noise;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_cmd(input logic [F_CMD_W-1:0] c, input logic [F_MUTEX_W-1:0] m,
                          input logic [F_PROC_W-1:0] p, input logic [F_THR_W-1:0] t,
                          output rsp_t want);
    req_t r;
    r.cmd         = c;
    r.mutex_index = m;
    r.proc_slot   = p;
    r.thread_slot = t;
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    want = apply_cmd(r);
    pending_rsp_q.push_back(want);
    idle_for(pick_gap());
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_rsp_q.size() != 0);
  endtask

  task automatic report_mismatch(string what, rsp_t want, rsp_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t: %s: expected st=%0d ai=%0d wv=%0d wt=%0d, got st=%0d ai=%0d wv=%0d wt=%0d",
               $realtime, what, want.status, want.alloc_index, want.woken_valid,
               want.woken_thread, got.status, got.alloc_index, got.woken_valid,
               got.woken_thread);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected result", '0, rsp);
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp.status !== want.status || rsp.alloc_index !== want.alloc_index ||
            rsp.woken_valid !== want.woken_valid || rsp.woken_thread !== want.woken_thread)
          report_mismatch("result mismatch", want, rsp);
      end
    end
  end

  task automatic test_directed();
    localparam logic [F_PROC_W-1:0] PA = 6'd0;
    localparam logic [F_PROC_W-1:0] PB = 6'd63;
    rsp_t                 got;
    logic [F_MUTEX_W-1:0] ma;
    logic [F_MUTEX_W-1:0] mb;
    logic [F_MUTEX_W-1:0] mc;
    send_cmd(CMD_ALLOC, 6'd0, PA, 4'd0, got);
    ma = got.alloc_index;
    send_cmd(CMD_ALLOC, 6'd63, PB, 4'd15, got);
    mb = got.alloc_index;
    send_cmd(CMD_LOCK, ma, PA, 4'd0, got);
    send_cmd(CMD_LOCK, ma, PA, 4'd0, got);
    send_cmd(CMD_LOCK, ma, PA, 4'd15, got);
    send_cmd(CMD_LOCK, ma, PA, 4'd5, got);
    send_cmd(CMD_LOCK, ma, PB, 4'd0, got);
    send_cmd(CMD_DEALLOC, ma, PA, 4'd0, got);
    send_cmd(CMD_UNLOCK, ma, PA, 4'd3, got);
    send_cmd(CMD_UNLOCK, ma, PA, 4'd0, got);
    send_cmd(CMD_UNLOCK, ma, PA, 4'd5, got);
    send_cmd(CMD_UNLOCK, ma, PA, 4'd15, got);
    send_cmd(CMD_UNLOCK, ma, PA, 4'd15, got);
    send_cmd(CMD_DEALLOC, ma, PB, 4'd0, got);
    send_cmd(CMD_DEALLOC, ma, PA, 4'd0, got);
    send_cmd(CMD_LOCK, ma, PA, 4'd0, got);
    send_cmd(CMD_UNLOCK, 6'd63, PA, 4'd0, got);
    send_cmd(CMD_LOCK, mb, PB, 4'd1, got);
    send_cmd(CMD_LOCK, mb, PB, 4'd2, got);
    send_cmd(CMD_ALLOC, 6'd0, PB, 4'd2, got);
    mc = got.alloc_index;
    send_cmd(CMD_LOCK, mc, PB, 4'd3, got);
    send_cmd(CMD_LOCK, mc, PB, 4'd2, got);
    send_cmd(CMD_UNLOCK, mb, PB, 4'd1, got);
    send_cmd(CMD_UNLOCK, mc, PB, 4'd3, got);
    send_cmd(CMD_LOCK, mb, PB, 4'd15, got);
    send_cmd(CMD_LOCK, mb, PB, 4'd0, got);
    send_cmd(CMD_UNLOCK, mb, PB, 4'd15, got);
  endtask

  task automatic test_table_full();
    rsp_t got;
    int   guard;
    guard = 0;
    do begin
      send_cmd(CMD_ALLOC, F_MUTEX_W'($urandom_range(0, 63)), proc_pool[$urandom_range(0, 3)],
               F_THR_W'($urandom_range(0, 15)), got);
      guard++;
    end while (got.status != ST_ERR && guard < NUM_MUTEXES + 4);
    send_cmd(CMD_ALLOC, 6'd0, proc_pool[0], 4'd7, got);
    wait_drain();
    for (int k = 0; k < NUM_MUTEXES; k++) begin
      if (ent_alloc[k] && !ent_locked[k] && $urandom_range(0, 3) != 0)
        send_cmd(CMD_DEALLOC, F_MUTEX_W'(k), ent_owner[k],
                 F_THR_W'($urandom_range(0, 15)), got);
    end
  endtask

  task automatic test_random(int n);
    rsp_t                 got;
    logic [F_PROC_W-1:0]  p;
    logic [F_THR_W-1:0]   t;
    int                   m;
    int                   sel;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 50) no_gap = 1'b1;
      if (i % 100 == 80) no_gap = 1'b0;
      if (i == n / 2) wait_drain();
      if ($urandom_range(0, 99) < 25) begin
        send_cmd(F_CMD_W'($urandom_range(0, 3)), F_MUTEX_W'($urandom_range(0, 63)),
                 F_PROC_W'($urandom_range(0, 63)), F_THR_W'($urandom_range(0, 15)), got);
      end else begin
        p   = proc_pool[$urandom_range(0, 3)];
        t   = F_THR_W'($urandom_range(0, 15));
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
          send_cmd(CMD_ALLOC, F_MUTEX_W'($urandom_range(0, 63)), p, t, got);
        end else if (sel < 25) begin
          m = pick_owned(p, 1);
          if (m == NONE) m = $urandom_range(0, 63);
          send_cmd(CMD_DEALLOC, F_MUTEX_W'(m), p, t, got);
        end else if (sel < 60) begin
          m = pick_owned(p, 0);
          if (m == NONE) m = $urandom_range(0, 63);
          send_cmd(CMD_LOCK, F_MUTEX_W'(m), p, t, got);
        end else begin
          m = pick_owned(p, 2);
          if (m == NONE) m = pick_owned(p, 0);
          if (m == NONE) m = $urandom_range(0, 63);
          if (ent_hv[m] && $urandom_range(0, 9) < 8) t = ent_ht[m];
          send_cmd(CMD_UNLOCK, F_MUTEX_W'(m), p, t, got);
        end
      end
    end
  endtask

  initial begin
    proc_pool[0] = 6'd0;
    proc_pool[1] = 6'd63;
    proc_pool[2] = F_PROC_W'($urandom_range(1, 31));
    proc_pool[3] = F_PROC_W'($urandom_range(32, 62));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(500);
    wait_drain();
    repeat (80) @(posedge clk);
    if (pending_rsp_q.size() != 0) begin
      err_count += pending_rsp_q.size();
      $display("%0d results never arrived", pending_rsp_q.size());
    end
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
